// ----- rtl/gtam_pkg.sv -----
`timescale 1ns / 1ps
package gtam_pkg;

	// calibration length and accumulator size
	localparam int CALIB_SAMPLES = 20;
	localparam int ACC_W         = 40;

	// field widths
	localparam int RATE_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int BAND_W     = 15;
	localparam int TARGET_W   = 9;
	localparam int ANGLE_W    = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// calibration sum and divide-by-constant via reciprocal
	localparam int CAL_LOG   = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
	localparam int CNT_W     = CAL_LOG;
	localparam int SUM_W     = RATE_W + CAL_LOG;
	localparam int DIV_SHIFT = SUM_W + CAL_LOG;
	localparam int RECIP_W   = SUM_W + 2;
	localparam int QPROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

	// corrected rate and scaled step
	localparam int DIFF_W = RATE_W + 1;
	localparam int STEP_W = DIFF_W + SCALE_W;

	// 655360 units per degree
	localparam int UNITS_PER_DEG = 655360;
	localparam int THR_W         = TARGET_W + $clog2(UNITS_PER_DEG);

	// register reset values
	localparam int TARGET_RESET = 180;
	localparam int SCALE_RESET  = 2400;
	localparam int BAND_RESET   = 30;

	// command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_CALIB = 2'd1,
		MODE_TURN  = 2'd2,
		MODE_DONE  = 2'd3
	} mode_t;

	// what the front stage made of an item
	typedef enum logic [1:0] {
		KIND_START,
		KIND_CAL,
		KIND_CAL_END,
		KIND_SAMPLE
	} kind_t;

	typedef struct packed {
		logic              cmd;
		logic [RATE_W-1:0] rate_y;
		logic [RATE_W-1:0] rate_z;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                phase;
		logic                      drive_on;
		logic                      done_res;
		logic signed [ANGLE_W-1:0] angle_y;
		logic signed [ANGLE_W-1:0] angle_z;
	} out_item_t;

	typedef struct packed {
		logic [SCALE_W-1:0] rate_scale;
		logic [BAND_W-1:0]  dead_band;
		logic [THR_W-1:0]   thr;
	} cfg_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [STEP_W-1:0] step_y;
		logic signed [STEP_W-1:0] step_z;
	} front_t;

endpackage

// ----- rtl/gtam_cfg.sv -----
`timescale 1ns / 1ps
module gtam_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gtam_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtam_pkg::CFG_DATA_W-1:0] cfg_data,
	output gtam_pkg::cfg_t                 cfg
);
	import gtam_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [BAND_W-1:0]  band_q;
	logic [THR_W-1:0]   thr_q;

	// target kept as a ready-made threshold in accumulator units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(SCALE_RESET);
			band_q  <= BAND_W'(BAND_RESET);
			thr_q   <= THR_W'(TARGET_RESET * UNITS_PER_DEG);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TARGET: thr_q <= THR_W'(cfg_data[TARGET_W-1:0]) * THR_W'(UNITS_PER_DEG);
				CFG_SCALE:  scale_q <= cfg_data[SCALE_W-1:0];
				CFG_BAND:   band_q <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.rate_scale = scale_q;
	assign cfg.dead_band  = band_q;
	assign cfg.thr        = thr_q;

endmodule

// ----- rtl/gtam_front.sv -----
`timescale 1ns / 1ps
module gtam_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_s1,
	input  gtam_pkg::in_item_t sample,
	input  logic               load_s2,
	input  gtam_pkg::cfg_t     cfg,
	output gtam_pkg::front_t   front_s2
);
	import gtam_pkg::*;

	in_item_t                  item_s1;
	logic                      cal_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SUM_W-1:0]          sum_y_q, sum_z_q;
	logic signed [RATE_W-1:0]  bias_y_q, bias_z_q;

	logic [SUM_W-1:0]          sum_y_d, sum_z_d;
	logic [QPROD_W-1:0]        qprod_y, qprod_z;
	logic signed [RATE_W-1:0]  quot_y, quot_z;
	logic                      last;
	front_t                    front_d;

	// signed rate minus bias, deadband, times scale
	function automatic logic signed [STEP_W-1:0] scale_step(
		input logic [RATE_W-1:0]         raw,
		input logic signed [RATE_W-1:0]  bias,
		input logic [BAND_W-1:0]         band,
		input logic [SCALE_W-1:0]        scale
	);
		logic signed [DIFF_W-1:0] v;
		logic [DIFF_W-1:0]        mag;
		v   = DIFF_W'($signed(raw)) - DIFF_W'(bias);
		mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
		if (mag < DIFF_W'(band))
			v = '0;
		return STEP_W'(v) * STEP_W'($signed({1'b0, scale}));
	endfunction

	always_ff @(posedge clk) begin
		if (load_s1)
			item_s1 <= sample;
	end

	// running sums; quotient by reciprocal multiply, exact over the sum range
	always_comb begin
		sum_y_d = sum_y_q + SUM_W'(item_s1.rate_y);
		sum_z_d = sum_z_q + SUM_W'(item_s1.rate_z);
		qprod_y = QPROD_W'(sum_y_d) * QPROD_W'(DIV_RECIP);
		qprod_z = QPROD_W'(sum_z_d) * QPROD_W'(DIV_RECIP);
		quot_y  = $signed(qprod_y[DIV_SHIFT +: RATE_W]);
		quot_z  = $signed(qprod_z[DIV_SHIFT +: RATE_W]);
		last    = (cnt_q == CNT_W'(CALIB_SAMPLES - 1));
	end

	always_comb begin
		front_d.step_y = scale_step(item_s1.rate_y, bias_y_q, cfg.dead_band, cfg.rate_scale);
		front_d.step_z = scale_step(item_s1.rate_z, bias_z_q, cfg.dead_band, cfg.rate_scale);
		if (item_s1.cmd == CMD_START)
			front_d.kind = KIND_START;
		else if (cal_q)
			front_d.kind = last ? KIND_CAL_END : KIND_CAL;
		else
			front_d.kind = KIND_SAMPLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			cnt_q    <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			bias_y_q <= '0;
			bias_z_q <= '0;
		end else if (load_s2) begin
			if (item_s1.cmd == CMD_START) begin
				cal_q   <= 1'b1;
				cnt_q   <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
			end else if (cal_q) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				sum_y_q <= sum_y_d;
				sum_z_q <= sum_z_d;
				if (last) begin
					cal_q    <= 1'b0;
					bias_y_q <= quot_y;
					bias_z_q <= quot_z;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2)
			front_s2 <= front_d;
	end

endmodule

// ----- rtl/gtam_integ.sv -----
`timescale 1ns / 1ps
module gtam_integ (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gtam_pkg::front_t    front_s2,
	input  gtam_pkg::cfg_t      cfg,
	output gtam_pkg::out_item_t result
);
	import gtam_pkg::*;

	localparam int SUMA_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	mode_t                    mode_q, mode_d;
	logic signed [ACC_W-1:0]  acc_y_q, acc_z_q, acc_y_d, acc_z_d;
	logic signed [ACC_W-1:0]  sat_y, sat_z;
	logic                     hit_cur, hit_new;
	out_item_t                res_q, res_d;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  a,
		input logic signed [STEP_W-1:0] inc
	);
		logic signed [SUMA_W-1:0] s;
		s = SUMA_W'(a) + SUMA_W'(inc);
		if (s > SUMA_W'(ACC_MAX))
			return ACC_MAX;
		else if (s < SUMA_W'(ACC_MIN))
			return ACC_MIN;
		else
			return ACC_W'(s);
	endfunction

	function automatic logic reached(
		input logic signed [ACC_W-1:0] a,
		input logic [THR_W-1:0]        thr
	);
		logic signed [ACC_W-1:0] t;
		t = $signed(ACC_W'(thr));
		return (a >= t) || (a <= -t);
	endfunction

	always_comb begin
		sat_y   = sat_add(acc_y_q, front_s2.step_y);
		sat_z   = sat_add(acc_z_q, front_s2.step_z);
		hit_cur = reached(acc_y_q, cfg.thr) || reached(acc_z_q, cfg.thr);
		hit_new = reached(sat_y, cfg.thr) || reached(sat_z, cfg.thr);
	end

	always_comb begin
		acc_y_d = acc_y_q;
		acc_z_d = acc_z_q;
		case (front_s2.kind)
			KIND_START: begin
				acc_y_d = '0;
				acc_z_d = '0;
			end
			KIND_SAMPLE: begin
				if (mode_q == MODE_TURN) begin
					acc_y_d = sat_y;
					acc_z_d = sat_z;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		unique case (front_s2.kind)
			KIND_START:   mode_d = MODE_CALIB;
			KIND_CAL:     mode_d = mode_q;
			KIND_CAL_END: mode_d = hit_cur ? MODE_DONE : MODE_TURN;
			KIND_SAMPLE: begin
				if (mode_q == MODE_TURN && hit_new)
					mode_d = MODE_DONE;
			end
			default:      mode_d = mode_q;
		endcase
	end

	// result fields
	always_comb begin
		res_d.phase    = mode_d;
		res_d.drive_on = (mode_d == MODE_TURN);
		res_d.done_res = (mode_d == MODE_DONE) && (mode_q != MODE_DONE);
		res_d.angle_y  = ANGLE_W'(acc_y_d);
		res_d.angle_z  = ANGLE_W'(acc_z_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			acc_y_q <= acc_y_d;
			acc_z_q <= acc_z_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_d;
	end

	assign result = res_q;

endmodule

// ----- rtl/gyro_turn_angle_monitor.sv -----
`timescale 1ns / 1ps
// channel   signals                              payload
// sample    sample_valid, sample_stall, sample   in_item_t: cmd, rate_y, rate_z
// result    result_valid, result_stall, result   out_item_t: phase, drive_on, done_res,
//                                                 angle_y, angle_z
// config    cfg_we, cfg_idx, cfg_data            target_angle, rate_scale, dead_band
//
// One item per cycle sustained while result_stall stays low; each result passes
// the input register, front stage and result register after its item is taken.
// The rate is set by the accumulator loop: saturating add and threshold compare
// close combinationally in the integrator stage.
// Reset leaves the pipeline empty, phase idle, registers at 180 deg / 2400 / 30.
// A stalled result holds the result register; earlier stages still move into
// empty slots. sample_stall rises only when all three stages hold an item.
module gyro_turn_angle_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  gtam_pkg::in_item_t              sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output gtam_pkg::out_item_t             result,
	input  logic                            cfg_we,
	input  logic [gtam_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtam_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gtam_pkg::*;

	cfg_t   cfg;
	front_t front_s2;

	logic valid_s1, valid_s2, res_v_q;
	logic res_ready, s2_ready, s1_ready;
	logic load_s1, load_s2, load_out;

	// each stage moves when its successor is empty or moving too
	assign res_ready = !res_v_q || !result_stall;
	assign s2_ready  = !valid_s2 || res_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign load_s1   = sample_valid && s1_ready;
	assign load_s2   = valid_s1 && s2_ready;
	assign load_out  = valid_s2 && res_ready;

	assign sample_stall = !s1_ready;
	assign result_valid = res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= sample_valid;
			if (s2_ready)
				valid_s2 <= valid_s1;
			if (res_ready)
				res_v_q <= valid_s2;
		end
	end

	gtam_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// calibration sums, bias and scaled rate steps
	gtam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_s1  (load_s1),
		.sample   (sample),
		.load_s2  (load_s2),
		.cfg      (cfg),
		.front_s2 (front_s2)
	);

	// phase control, saturating angle accumulators, result register
	gtam_integ u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (load_out),
		.front_s2 (front_s2),
		.cfg      (cfg),
		.result   (result)
	);

	// stall only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2 && res_v_q))
		else $error("sample stalled with a free pipeline stage");

	// done is only reported together with the finished phase
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.done_res) |-> (result.phase == MODE_DONE))
		else $error("done reported outside finished phase");

	// no integration during calibration
	a_calib_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.phase == MODE_CALIB) |->
			(result.angle_y == '0 && result.angle_z == '0 && !result.drive_on))
		else $error("nonzero angle or drive during calibration");

endmodule

// ----- tb/gtam_angle_tracker.sv -----
`timescale 1ns / 1ps
module gtam_angle_tracker
	import gtam_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_stall,
	input  in_item_t              sample,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint ACC_MAX     = (longint'(1) << (ACC_W - 1)) - 1;
	localparam longint ACC_MIN     = -ACC_MAX - 1;
	localparam int     MAX_REPORTS = 30;

	// register copies
	logic [TARGET_W-1:0] target_deg;
	logic [SCALE_W-1:0]  scale;
	logic [BAND_W-1:0]   band;

	// turn state
	mode_t       mode;
	int unsigned cal_count;
	int unsigned sum_y;
	int unsigned sum_z;
	int          bias_y;
	int          bias_z;
	longint      acc_y;
	longint      acc_z;

	out_item_t predicted_results[$];
	int        results_seen;

	function automatic int as_signed16(input logic [RATE_W-1:0] w);
		return int'($signed(w));
	endfunction

	// bias-corrected, deadbanded and scaled rate
	function automatic longint rate_step(input logic [RATE_W-1:0] raw, input int bias);
		int v;
		int mag;
		v = as_signed16(raw) - bias;
		mag = (v < 0) ? -v : v;
		if (mag < int'(band)) v = 0;
		return longint'(v) * longint'(scale);
	endfunction

	function automatic longint add_sat(input longint a, input longint inc);
		if (inc > 0 && a > ACC_MAX - inc) return ACC_MAX;
		if (inc < 0 && a < ACC_MIN - inc) return ACC_MIN;
		return a + inc;
	endfunction

	function automatic bit past_target(input longint a);
		longint lim;
		lim = longint'(target_deg) * UNITS_PER_DEG;
		return (a >= lim) || (a <= -lim);
	endfunction

	task automatic advance_turn(input in_item_t it, output out_item_t res);
		logic done;
		done = 1'b0;
		if (it.cmd == CMD_START) begin
			mode = MODE_CALIB;
			cal_count = 0;
			sum_y = 0;
			sum_z = 0;
			acc_y = 0;
			acc_z = 0;
		end else if (mode == MODE_CALIB) begin
			sum_y += it.rate_y;
			sum_z += it.rate_z;
			cal_count++;
			if (cal_count >= CALIB_SAMPLES) begin
				bias_y = as_signed16(RATE_W'(sum_y / CALIB_SAMPLES));
				bias_z = as_signed16(RATE_W'(sum_z / CALIB_SAMPLES));
				mode = MODE_TURN;
				// zero target trips right here
				if (past_target(acc_y) || past_target(acc_z)) begin
					mode = MODE_DONE;
					done = 1'b1;
				end
			end
		end else if (mode == MODE_TURN) begin
			acc_y = add_sat(acc_y, rate_step(it.rate_y, bias_y));
			acc_z = add_sat(acc_z, rate_step(it.rate_z, bias_z));
			if (past_target(acc_y) || past_target(acc_z)) begin
				mode = MODE_DONE;
				done = 1'b1;
			end
		end
		res.phase    = mode;
		res.drive_on = (mode == MODE_TURN);
		res.done_res = done;
		res.angle_y  = ANGLE_W'(acc_y);
		res.angle_z  = ANGLE_W'(acc_z);
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS) $display("result %0d: %s", results_seen, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			target_deg = TARGET_W'(TARGET_RESET);
			scale = SCALE_W'(SCALE_RESET);
			band = BAND_W'(BAND_RESET);
			mode = MODE_IDLE;
			cal_count = 0;
			sum_y = 0;
			sum_z = 0;
			bias_y = 0;
			bias_z = 0;
			acc_y = 0;
			acc_z = 0;
			predicted_results.delete();
			results_seen = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TARGET: target_deg = cfg_data[TARGET_W-1:0];
					CFG_SCALE:  scale = cfg_data[SCALE_W-1:0];
					CFG_BAND:   band = cfg_data[BAND_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				advance_turn(sample, want);
				predicted_results.push_back(want);
			end
			if (result_valid && !result_stall) begin
				got = result;
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result, phase %0d", got.phase));
				end else begin
					want = predicted_results.pop_front();
					if (got.phase !== want.phase)
						report_mismatch($sformatf("phase %0d, expected %0d",
							got.phase, want.phase));
					if (got.drive_on !== want.drive_on)
						report_mismatch($sformatf("drive_on %0d, expected %0d",
							got.drive_on, want.drive_on));
					if (got.done_res !== want.done_res)
						report_mismatch($sformatf("done_res %0d, expected %0d",
							got.done_res, want.done_res));
					if (got.angle_y !== want.angle_y)
						report_mismatch($sformatf("angle_y %0d, expected %0d",
							got.angle_y, want.angle_y));
					if (got.angle_z !== want.angle_z)
						report_mismatch($sformatf("angle_z %0d, expected %0d",
							got.angle_z, want.angle_z));
				end
				results_seen++;
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

// ----- tb/gyro_turn_angle_monitor_test.sv -----
`timescale 1ns / 1ps
module gyro_turn_angle_monitor_test
	import gtam_pkg::*;
;

	localparam int ITEM_TARGET    = 1550;
	localparam int WATCHDOG_LIMIT = 2000;
	// pipeline is three deep; a few spare cycles before touching registers
	localparam int PIPE_SETTLE    = 6;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	in_item_t              sample = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	out_item_t             result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;

	// sender burst bookkeeping
	int burst_left = 0;

	// receiver stall pattern
	int stall_style = 0;
	int style_left = 0;
	int stall_run = 0;

	int idle_cycles = 0;

	gyro_turn_angle_monitor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	gtam_angle_tracker tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: switches between no stalls, sparse random stalls and
	// runs of consecutive stalled cycles, changing style now and then.
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 2);
			style_left = $urandom_range(50, 400);
		end
		style_left--;
		if (stall_run > 0) begin
			stall_run--;
			result_stall <= 1'b1;
		end else begin
			case (stall_style)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_run = $urandom_range(0, 9);
						result_stall <= 1'b1;
					end else begin
						result_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// Watchdog: any handshake or register write restarts the count.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("gyro_turn_angle_monitor_test: FAIL");
			$finish;
		end
	end

	// Offer one item; returns right after the edge that took it.
	// A new burst may open with a gap, valid low during the gap.
	task automatic send_item(input logic cmd, input logic [RATE_W-1:0] ry,
			input logic [RATE_W-1:0] rz);
		int gap;
		in_item_t it;
		it.cmd = cmd;
		it.rate_y = ry;
		it.rate_z = rz;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample <= it;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// Stop sending and let every predicted result come back.
	task automatic drain_results();
		sample_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [RATE_W-1:0] jitter(input logic [RATE_W-1:0] center,
			input int spread);
		return RATE_W'(int'(center) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// bias centers lean toward the rails and the sign boundary
	function automatic logic [RATE_W-1:0] pick_center();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	function automatic int pick_spread();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 4;
			2: return 32767;
			3: return 1000;
			default: return 60;
		endcase
	endfunction

	initial begin
		int useful;
		int k;
		int turns;
		int cal_len;
		int turn_len;
		int spread;
		int reach;
		int drift_y;
		int drift_z;
		bit first_session;
		logic [RATE_W-1:0] center_y;
		logic [RATE_W-1:0] center_z;
		logic [CFG_DATA_W-1:0] word;

		useful = 0;
		first_session = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// samples while idle are ignored
		send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000);
		send_item(CMD_SAMPLE, 16'h8000, 16'h7FFF);
		drain_results();
		// zero target: finished on the item that ends calibration
		write_reg(CFG_TARGET, '0);
		send_item(CMD_START, 16'h1234, 16'hFFFF);
		// alternating rails: sums to the largest positive bias
		for (k = 0; k < CALIB_SAMPLES; k++)
			send_item(CMD_SAMPLE, k[0] ? 16'hFFFF : 16'h0000, k[0] ? 16'h0000 : 16'hFFFF);
		// sample once finished is ignored, then restart from finished
		send_item(CMD_SAMPLE, 16'h7FFF, 16'h8000);
		send_item(CMD_START, 16'h0000, 16'h0000);

		// --- random sessions: new settings, then a few turns ---
		while (useful < ITEM_TARGET) begin
			drain_results();
			if (first_session || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: word = '0;
					1: word = 16'd360;
					2: word = 16'h01FF;
					3: word = CFG_DATA_W'($urandom);
					default: word = CFG_DATA_W'($urandom_range(1, 25));
				endcase
				write_reg(CFG_TARGET, word);
			end
			if (first_session || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: word = 16'd1;
					1: word = 16'hFFFF;
					2: word = '0;
					3: word = CFG_DATA_W'($urandom);
					default: word = CFG_DATA_W'($urandom_range(200, 8000));
				endcase
				write_reg(CFG_SCALE, word);
			end
			if (first_session || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
					0: word = '0;
					1: word = 16'd32767;
					2: word = CFG_DATA_W'($urandom);
					default: word = CFG_DATA_W'($urandom_range(0, 300));
				endcase
				write_reg(CFG_BAND, word);
			end
			if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
			first_session = 1'b0;

			turns = $urandom_range(1, 4);
			repeat (turns) begin
				center_y = pick_center();
				center_z = pick_center();
				spread = pick_spread();
				send_item(CMD_START, RATE_W'($urandom), RATE_W'($urandom));
				useful++;
				// now and then calibration is cut short by the next start
				cal_len = ($urandom_range(0, 11) == 0) ?
					$urandom_range(0, CALIB_SAMPLES - 1) : CALIB_SAMPLES;
				for (k = 0; k < cal_len; k++) begin
					send_item(CMD_SAMPLE, jitter(center_y, spread), jitter(center_z, spread));
					useful++;
				end
				if (cal_len == CALIB_SAMPLES) begin
					case ($urandom_range(0, 5))
						0: reach = 0;
						1: reach = 40;
						2: reach = 32767;
						default: reach = 4000;
					endcase
					drift_y = int'($urandom_range(0, 2 * reach)) - reach;
					drift_z = int'($urandom_range(0, 2 * reach)) - reach;
					// a turn may run past done or be cut off by the next start
					turn_len = $urandom_range(1, 60);
					for (k = 0; k < turn_len; k++) begin
						if ($urandom_range(0, 9) == 0)
							send_item(CMD_SAMPLE, RATE_W'($urandom), RATE_W'($urandom));
						else
							send_item(CMD_SAMPLE,
								jitter(RATE_W'(int'(center_y) + drift_y), spread),
								jitter(RATE_W'(int'(center_z) + drift_z), spread));
						useful++;
					end
					repeat ($urandom_range(0, 2))
						send_item(CMD_SAMPLE, RATE_W'($urandom), RATE_W'($urandom));
				end
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("gyro_turn_angle_monitor_test: PASS");
		else
			$display("gyro_turn_angle_monitor_test: FAIL");
		$finish;
	end

endmodule
